[sv/isud_pkg.sv]
// isud_pkg: types, codes and constants for the interval set block.
// No dependencies; used by the interfaces, isud_cmp and the top module.
package isud_pkg;

  localparam int MAX_INTERVALS_DEF = 16;
  localparam int DW = 64;

  // Item commands
  typedef enum logic [1:0] {
    CMD_UNION = 2'd0,
    CMD_CUT   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE, ST_ORD, ST_RD, ST_EV, ST_EX, ST_FIN, ST_LRD, ST_LLD, ST_OUT
  } state_t;

  // Walk mode: still searching, holding a joined interval, or copying the rest
  typedef enum logic [1:0] {
    MD_SCAN, MD_JOIN, MD_COPY
  } mode_t;

  typedef struct packed {
    logic [1:0]           command;
    logic signed [DW-1:0] bound_a;
    logic signed [DW-1:0] bound_b;
  } in_word_t;

  typedef struct packed {
    logic signed [DW-1:0] range_start;
    logic signed [DW-1:0] range_end;
    logic                 entry_valid;
    logic                 last_entry;
    logic                 overflow;
  } out_word_t;

  // Compare flags of one entry against the bounds
  typedef struct packed {
    logic s_lt_lo, s_eq_lo, s_lt_hi, s_eq_hi;
    logic e_lt_lo, e_eq_lo, e_lt_hi, e_eq_hi;
  } cmp_t;

endpackage

[sv/isud_in_if.sv]
// isud_in_if: request channel, valid/ready with one command word.
// Depends on isud_pkg.
interface isud_in_if;
  logic               valid;
  logic               ready;
  isud_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/isud_out_if.sv]
// isud_out_if: listing channel, valid/ready with one interval word.
// Depends on isud_pkg.
interface isud_out_if;
  logic                valid;
  logic                ready;
  isud_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/isud_mem.sv]
// isud_mem: interval table storage, one write and one registered read port.
// Both table banks live here; no package dependency.
module isud_mem #(
  parameter int AW = 5,
  parameter int WW = 128
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [WW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [WW-1:0] rd_data
);
  logic [WW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

[sv/isud_cmp.sv]
// isud_cmp: shared signed compare unit, entry bounds against the range.
// Depends on isud_pkg.
module isud_cmp (
  input  logic signed [isud_pkg::DW-1:0] s,
  input  logic signed [isud_pkg::DW-1:0] e,
  input  logic signed [isud_pkg::DW-1:0] lo,
  input  logic signed [isud_pkg::DW-1:0] hi,
  output isud_pkg::cmp_t                 flags
);
  always_comb begin
    flags.s_lt_lo = s < lo;
    flags.s_eq_lo = s == lo;
    flags.s_lt_hi = s < hi;
    flags.s_eq_hi = s == hi;
    flags.e_lt_lo = e < lo;
    flags.e_eq_lo = e == lo;
    flags.e_lt_hi = e < hi;
    flags.e_eq_hi = e == hi;
  end
endmodule

[sv/interval_set_union_difference_top.sv]
// interval_set_union_difference_top: sorted disjoint interval set, union/cut/clear.
// Depends on isud_pkg, isud_in_if, isud_out_if, isud_mem, isud_cmp.
//
//   channel   role   word                                  per item
//   request   sink   command, bound_a, bound_b             one
//   listing   source range_start, range_end, flags         1..MAX_INTERVALS
//
// An item is accepted and its bounds ordered, then each of the N stored entries is
// read and evaluated in turn, with an extra write step for an insert, and the walk
// finishes; each listed word is then read, loaded and shown.
// The table walk reads one entry per step through the single memory read port.
// Synchronous reset empties the set; the table contents are not cleared.
// request is ready only in idle; a stalled listing word holds the sequencer.
module interval_set_union_difference_top #(
  parameter int MAX_INTERVALS = isud_pkg::MAX_INTERVALS_DEF
) (
  input logic        clk,
  input logic        rst,
  isud_in_if.sink    request,
  isud_out_if.source listing
);
  localparam int IW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int DW = isud_pkg::DW;

  isud_pkg::state_t state, state_next;
  isud_pkg::mode_t  mode, mode_next;
  logic             cur, cur_next;
  logic [IW-1:0]    i, i_next, k, k_next;
  logic [CW-1:0]    j, j_next, count, count_next;
  logic [1:0]       cmd, cmd_next;
  logic             ovf, ovf_next;
  logic signed [DW-1:0] lo, lo_next, hi, hi_next;
  logic signed [DW-1:0] pend_s, pend_s_next, pend_e, pend_e_next;
  logic signed [DW-1:0] ex_s, ex_s_next, ex_e, ex_e_next;
  isud_pkg::out_word_t  out_word, out_word_next;

  logic                 wr_en;
  logic signed [DW-1:0] wr_s, wr_e, rd_s, rd_e, cmp_s, cmp_lo;
  logic [2*DW-1:0]      rd_data;
  logic [IW:0]          rd_addr;
  isud_pkg::cmp_t       f;

  // Table storage: bank select on top of the entry index
  isud_mem #(.AW(IW + 1), .WW(2 * DW)) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr({~cur, j[IW-1:0]}),
    .wr_data({wr_s, wr_e}),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_addr = {cur, (state == isud_pkg::ST_LRD) ? k : i};
  assign rd_s    = rd_data[2*DW-1:DW];
  assign rd_e    = rd_data[DW-1:0];

  // Shared compare: orders the bounds, then tests each entry
  assign cmp_s  = (state == isud_pkg::ST_ORD) ? lo : rd_s;
  assign cmp_lo = (state == isud_pkg::ST_ORD) ? hi : lo;

  isud_cmp u_cmp (.s(cmp_s), .e(rd_e), .lo(cmp_lo), .hi(hi), .flags(f));

  assign request.ready = (state == isud_pkg::ST_IDLE);
  assign listing.valid = (state == isud_pkg::ST_OUT);
  assign listing.data  = out_word;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= isud_pkg::ST_IDLE;
      mode  <= isud_pkg::MD_SCAN;
      cur   <= 1'b0;
      i     <= '0;
      k     <= '0;
      j     <= '0;
      count <= '0;
      cmd   <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      mode  <= mode_next;
      cur   <= cur_next;
      i     <= i_next;
      k     <= k_next;
      j     <= j_next;
      count <= count_next;
      cmd   <= cmd_next;
      ovf   <= ovf_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo       <= lo_next;
    hi       <= hi_next;
    pend_s   <= pend_s_next;
    pend_e   <= pend_e_next;
    ex_s     <= ex_s_next;
    ex_e     <= ex_e_next;
    out_word <= out_word_next;
  end

  // Sequencer
  always_comb begin
    logic s_gt_lo, s_gt_hi, s_ge_hi, e_ge_lo, e_ge_hi, e_gt_hi, full, adv;
    s_gt_lo = !(f.s_lt_lo || f.s_eq_lo);
    s_gt_hi = !(f.s_lt_hi || f.s_eq_hi);
    s_ge_hi = !f.s_lt_hi;
    e_ge_lo = !f.e_lt_lo;
    e_ge_hi = !f.e_lt_hi;
    e_gt_hi = !(f.e_lt_hi || f.e_eq_hi);
    full    = (count == CW'(MAX_INTERVALS));
    adv     = 1'b0;

    state_next    = state;
    mode_next     = mode;
    cur_next      = cur;
    i_next        = i;
    k_next        = k;
    count_next    = count;
    cmd_next      = cmd;
    ovf_next      = ovf;
    lo_next       = lo;
    hi_next       = hi;
    pend_s_next   = pend_s;
    pend_e_next   = pend_e;
    ex_s_next     = ex_s;
    ex_e_next     = ex_e;
    out_word_next = out_word;
    wr_en         = 1'b0;
    wr_s          = rd_s;
    wr_e          = rd_e;

    unique case (state)
      isud_pkg::ST_IDLE: begin
        if (request.valid) begin
          cmd_next   = request.data.command;
          lo_next    = request.data.bound_a;
          hi_next    = request.data.bound_b;
          ovf_next   = 1'b0;
          mode_next  = isud_pkg::MD_SCAN;
          i_next     = '0;
          k_next     = '0;
          state_next = isud_pkg::ST_ORD;
        end
      end
      isud_pkg::ST_ORD: begin
        if (!f.s_lt_lo) begin
          lo_next = hi;
          hi_next = lo;
        end
        if (cmd == isud_pkg::CMD_CLEAR) begin
          count_next = '0;
          state_next = isud_pkg::ST_LRD;
        end else if (cmd == isud_pkg::CMD_NOP) begin
          state_next = isud_pkg::ST_LRD;
        end else if (count == '0) begin
          state_next = isud_pkg::ST_FIN;
        end else begin
          state_next = isud_pkg::ST_RD;
        end
      end
      isud_pkg::ST_RD: begin
        state_next = isud_pkg::ST_EV;
      end
      isud_pkg::ST_EV: begin
        adv = 1'b1;
        if (mode == isud_pkg::MD_COPY) begin
          wr_en = 1'b1;
        end else if (cmd == isud_pkg::CMD_UNION) begin
          if (mode == isud_pkg::MD_SCAN) begin
            if (s_gt_lo) begin
              if (s_gt_hi) begin
                mode_next = isud_pkg::MD_COPY;
                wr_en     = 1'b1;
                if (full) begin
                  ovf_next = 1'b1;
                end else begin
                  wr_s      = lo;
                  wr_e      = hi;
                  ex_s_next = rd_s;
                  ex_e_next = rd_e;
                  adv       = 1'b0;
                end
              end else if (e_ge_hi) begin
                wr_en     = 1'b1;
                wr_s      = lo;
                mode_next = isud_pkg::MD_COPY;
              end else begin
                pend_s_next = lo;
                pend_e_next = hi;
                mode_next   = isud_pkg::MD_JOIN;
              end
            end else if (e_ge_lo) begin
              if (e_ge_hi) begin
                wr_en     = 1'b1;
                mode_next = isud_pkg::MD_COPY;
              end else begin
                pend_s_next = rd_s;
                pend_e_next = hi;
                mode_next   = isud_pkg::MD_JOIN;
              end
            end else begin
              wr_en = 1'b1;
            end
          end else begin
            // joined: swallow entries inside the range, fuse a touching one
            if (!e_ge_hi) begin
              wr_en = 1'b0;
            end else if (!s_gt_hi) begin
              wr_en     = 1'b1;
              wr_s      = pend_s;
              mode_next = isud_pkg::MD_COPY;
            end else begin
              wr_en     = 1'b1;
              wr_s      = pend_s;
              wr_e      = pend_e;
              ex_s_next = rd_s;
              ex_e_next = rd_e;
              mode_next = isud_pkg::MD_COPY;
              adv       = 1'b0;
            end
          end
        end else begin
          if (mode == isud_pkg::MD_SCAN) begin
            if (!f.s_lt_lo) begin
              if (s_ge_hi) begin
                wr_en     = 1'b1;
                mode_next = isud_pkg::MD_COPY;
              end else if (e_gt_hi) begin
                wr_en     = 1'b1;
                wr_s      = hi;
                mode_next = isud_pkg::MD_COPY;
              end else begin
                mode_next = isud_pkg::MD_JOIN;
              end
            end else if (e_ge_lo) begin
              wr_en = 1'b1;
              wr_e  = lo;
              if (e_gt_hi) begin
                // split: upper piece follows unless the table is full
                mode_next = isud_pkg::MD_COPY;
                if (full) begin
                  ovf_next = 1'b1;
                end else begin
                  ex_s_next = hi;
                  ex_e_next = rd_e;
                  adv       = 1'b0;
                end
              end else begin
                mode_next = isud_pkg::MD_JOIN;
              end
            end else begin
              wr_en = 1'b1;
            end
          end else begin
            if (e_gt_hi) begin
              wr_en     = 1'b1;
              mode_next = isud_pkg::MD_COPY;
              if (!s_gt_hi) begin
                wr_s = hi;
              end
            end
          end
        end
        if (!adv) begin
          state_next = isud_pkg::ST_EX;
        end
      end
      isud_pkg::ST_EX: begin
        wr_en = 1'b1;
        wr_s  = ex_s;
        wr_e  = ex_e;
        adv   = 1'b1;
      end
      isud_pkg::ST_FIN: begin
        if (cmd == isud_pkg::CMD_UNION) begin
          if (mode == isud_pkg::MD_JOIN) begin
            wr_en = 1'b1;
            wr_s  = pend_s;
            wr_e  = pend_e;
          end else if (mode == isud_pkg::MD_SCAN) begin
            if (full) begin
              ovf_next = 1'b1;
            end else begin
              wr_en = 1'b1;
              wr_s  = lo;
              wr_e  = hi;
            end
          end
        end
        count_next = j + CW'(wr_en);
        cur_next   = ~cur;
        state_next = isud_pkg::ST_LRD;
      end
      isud_pkg::ST_LRD: begin
        state_next = isud_pkg::ST_LLD;
      end
      isud_pkg::ST_LLD: begin
        if (count == '0) begin
          out_word_next = '{range_start: '0, range_end: '0, entry_valid: 1'b0,
                            last_entry: 1'b1, overflow: ovf};
        end else begin
          out_word_next = '{range_start: rd_s, range_end: rd_e, entry_valid: 1'b1,
                            last_entry: (CW'(k) == count - CW'(1)), overflow: ovf};
        end
        state_next = isud_pkg::ST_OUT;
      end
      isud_pkg::ST_OUT: begin
        if (listing.ready) begin
          if (out_word.last_entry) begin
            state_next = isud_pkg::ST_IDLE;
          end else begin
            k_next     = k + IW'(1);
            state_next = isud_pkg::ST_LRD;
          end
        end
      end
      default: state_next = isud_pkg::ST_IDLE;
    endcase

    // Step to the next stored entry or finish the walk
    if (adv) begin
      if (CW'(i) + CW'(1) < count) begin
        i_next     = i + IW'(1);
        state_next = isud_pkg::ST_RD;
      end else begin
        state_next = isud_pkg::ST_FIN;
      end
    end
  end

  // New-table write count; cleared when an item is taken
  assign j_next = (state == isud_pkg::ST_IDLE) ? '0 : j + CW'(wr_en);

  // Checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_INTERVALS)) else $error("entry count above capacity");
  a_write_cap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> j < CW'(MAX_INTERVALS)) else $error("table write past capacity");
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(request.ready && listing.valid)) else $error("idle while a word is shown");
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (listing.valid && listing.ready && listing.data.last_entry) |=>
      state == isud_pkg::ST_IDLE) else $error("listing did not end");
  a_bank_flip: assert property (@(posedge clk) disable iff (rst)
    state == isud_pkg::ST_FIN |=> cur != $past(cur)) else $error("bank not swapped");
endmodule
